// File: sv/wpsm_pkg.sv
// ----------------------------------------------------------------------------
// wpsm_pkg
// Shared types and constants of the worker pool slot manager: slot table
// geometry, command, state and result codes, and the channel layouts.
// ----------------------------------------------------------------------------
package wpsm_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);

    localparam int ID_W       = 31;
    localparam int STATE_W    = 2;
    localparam int CODE_W     = 3;
    localparam int SLOT_IDX_W = 6;
    localparam int GROW_W     = 5;
    localparam int COUNT_W    = 7;
    localparam int LIMIT_W    = 7;
    localparam int DELTA_W    = 5;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_SET     = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_EVAL    = 2'd3
    } cmd_t;

    localparam logic [STATE_W-1:0] ST_FREE = 2'd0;
    localparam logic [STATE_W-1:0] ST_IDLE = 2'd1;
    localparam logic [STATE_W-1:0] ST_WORK = 2'd2;

    localparam logic [CODE_W-1:0] RC_OK       = 3'd0;
    localparam logic [CODE_W-1:0] RC_FULL     = 3'd1;
    localparam logic [CODE_W-1:0] RC_NOFREE   = 3'd2;
    localparam logic [CODE_W-1:0] RC_MIN      = 3'd3;
    localparam logic [CODE_W-1:0] RC_NOIDLE   = 3'd4;
    localparam logic [CODE_W-1:0] RC_NOTFOUND = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WORKERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORKERS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DELTA  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [STATE_W-1:0] st;
    } slot_entry_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [ID_W-1:0]    worker_id;
        logic [STATE_W-1:0] new_state;
    } req_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] min_workers;
        logic [LIMIT_W-1:0] max_workers;
        logic [DELTA_W-1:0] idle_delta;
    } cfg_t;

    // Declared from the highest field down so that result_code packs lowest.
    typedef struct packed {
        logic [COUNT_W-1:0]    working_count;
        logic [COUNT_W-1:0]    idle_count;
        logic [COUNT_W-1:0]    active_count;
        logic [COUNT_W-1:0]    shrink_count;
        logic [GROW_W-1:0]     grow_count;
        logic [ID_W-1:0]       released_id;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [CODE_W-1:0]     result_code;
    } rsp_t;

endpackage

// File: sv/wpsm_table.sv
// ----------------------------------------------------------------------------
// wpsm_table
// Slot table memory: one write port, one registered read port. A valid bit
// per entry makes entries that were never written read as a free slot.
// ----------------------------------------------------------------------------
module wpsm_table
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [wpsm_pkg::SLOT_AW-1:0]   rd_addr,
    input  logic                           wr_en,
    input  logic [wpsm_pkg::SLOT_AW-1:0]   wr_addr,
    input  wpsm_pkg::slot_entry_t          wr_entry,
    output wpsm_pkg::slot_entry_t          rd_entry
);

    wpsm_pkg::slot_entry_t           mem [wpsm_pkg::SLOTS];
    wpsm_pkg::slot_entry_t           rd_q_reg;
    logic [wpsm_pkg::SLOTS-1:0]      valid_reg;
    logic                            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // A free slot is all zeros: id cleared and state free.
    assign rd_entry = rd_valid_reg ? rd_q_reg : '0;

endmodule

// File: sv/wpsm_ctrl.sv
// ----------------------------------------------------------------------------
// wpsm_ctrl
// Command sequencer: checks the limits, scans the slot table one entry per
// cycle, writes the matching entry back and keeps the pool counters.
// ----------------------------------------------------------------------------
module wpsm_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  wpsm_pkg::req_t                 req,
    output logic                           req_ready,
    input  wpsm_pkg::cfg_t                 cfg,
    output logic                           rsp_valid,
    output wpsm_pkg::rsp_t                 rsp,
    input  logic                           rsp_ready,
    output logic                           tbl_rd_en,
    output logic [wpsm_pkg::SLOT_AW-1:0]   tbl_rd_addr,
    output logic                           tbl_wr_en,
    output logic [wpsm_pkg::SLOT_AW-1:0]   tbl_wr_addr,
    output wpsm_pkg::slot_entry_t          tbl_wr_entry,
    input  wpsm_pkg::slot_entry_t          tbl_rd_entry
);

    localparam int CMP_W = (wpsm_pkg::CNT_W > wpsm_pkg::LIMIT_W) ?
                           wpsm_pkg::CNT_W : wpsm_pkg::LIMIT_W;
    localparam logic [wpsm_pkg::SLOT_AW-1:0] LAST_SLOT =
        wpsm_pkg::SLOT_AW'(wpsm_pkg::SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                              state_reg;
    wpsm_pkg::req_t                      req_reg;
    logic [wpsm_pkg::SLOT_AW-1:0]        chk_reg;
    logic [wpsm_pkg::CODE_W-1:0]         code_reg;
    logic [wpsm_pkg::SLOT_AW-1:0]        slot_reg;
    logic [wpsm_pkg::ID_W-1:0]           rel_reg;
    logic [wpsm_pkg::GROW_W-1:0]         grow_reg;
    logic [wpsm_pkg::COUNT_W-1:0]        shrink_reg;
    logic [wpsm_pkg::CNT_W-1:0]          active_reg;
    logic [wpsm_pkg::CNT_W-1:0]          idle_reg;
    logic [wpsm_pkg::CNT_W-1:0]          work_reg;

    logic [wpsm_pkg::CNT_W-1:0]          active_next;
    logic [wpsm_pkg::CNT_W-1:0]          idle_next;
    logic [wpsm_pkg::CNT_W-1:0]          work_next;
    logic                                hit;
    logic [wpsm_pkg::CODE_W-1:0]         miss_code;
    logic [wpsm_pkg::LIMIT_W-1:0]        delta_x3;
    logic [CMP_W-1:0]                    active_cmp;
    logic [CMP_W-1:0]                    idle_cmp;

    assign delta_x3   = wpsm_pkg::LIMIT_W'({2'b00, cfg.idle_delta})
                      + wpsm_pkg::LIMIT_W'({1'b0, cfg.idle_delta, 1'b0});
    assign active_cmp = CMP_W'(active_reg);
    assign idle_cmp   = CMP_W'(idle_reg);

    always_comb
    begin
        case (req_reg.cmd)
            wpsm_pkg::CMD_ADD:     hit = (tbl_rd_entry.st == wpsm_pkg::ST_FREE);
            wpsm_pkg::CMD_RELEASE: hit = (tbl_rd_entry.st == wpsm_pkg::ST_IDLE);
            wpsm_pkg::CMD_SET:     hit = (tbl_rd_entry.id == req_reg.worker_id);
            default:               hit = 1'b0;
        endcase

        case (req_reg.cmd)
            wpsm_pkg::CMD_ADD:     miss_code = wpsm_pkg::RC_NOFREE;
            wpsm_pkg::CMD_RELEASE: miss_code = wpsm_pkg::RC_NOIDLE;
            wpsm_pkg::CMD_SET:     miss_code = wpsm_pkg::RC_NOTFOUND;
            default:               miss_code = wpsm_pkg::RC_OK;
        endcase
    end

    // Write-back of the hit entry and the counter moves it causes.
    always_comb
    begin
        tbl_wr_en    = 1'b0;
        tbl_wr_entry = '0;
        active_next  = active_reg;
        idle_next    = idle_reg;
        work_next    = work_reg;
        if (state_reg == S_SCAN && hit)
        begin
            case (req_reg.cmd)
                wpsm_pkg::CMD_ADD:
                begin
                    tbl_wr_en       = 1'b1;
                    tbl_wr_entry.id = req_reg.worker_id;
                    tbl_wr_entry.st = wpsm_pkg::ST_IDLE;
                    active_next     = active_reg + wpsm_pkg::CNT_W'(1);
                    idle_next       = idle_reg + wpsm_pkg::CNT_W'(1);
                end
                wpsm_pkg::CMD_RELEASE:
                begin
                    tbl_wr_en    = 1'b1;
                    tbl_wr_entry = '0;
                    active_next  = active_reg - wpsm_pkg::CNT_W'(1);
                    idle_next    = idle_reg - wpsm_pkg::CNT_W'(1);
                end
                wpsm_pkg::CMD_SET:
                begin
                    // A target state outside free, idle and working changes nothing.
                    if (req_reg.new_state == wpsm_pkg::ST_FREE ||
                        req_reg.new_state == wpsm_pkg::ST_IDLE ||
                        req_reg.new_state == wpsm_pkg::ST_WORK)
                    begin
                        tbl_wr_en       = 1'b1;
                        tbl_wr_entry.st = req_reg.new_state;
                        tbl_wr_entry.id = (req_reg.new_state == wpsm_pkg::ST_FREE) ?
                                          '0 : tbl_rd_entry.id;
                        active_next = active_reg
                            + wpsm_pkg::CNT_W'(tbl_rd_entry.st == wpsm_pkg::ST_FREE)
                            - wpsm_pkg::CNT_W'(req_reg.new_state == wpsm_pkg::ST_FREE);
                        idle_next = idle_reg
                            - wpsm_pkg::CNT_W'(tbl_rd_entry.st == wpsm_pkg::ST_IDLE)
                            + wpsm_pkg::CNT_W'(req_reg.new_state == wpsm_pkg::ST_IDLE);
                        work_next = work_reg
                            - wpsm_pkg::CNT_W'(tbl_rd_entry.st == wpsm_pkg::ST_WORK)
                            + wpsm_pkg::CNT_W'(req_reg.new_state == wpsm_pkg::ST_WORK);
                    end
                end
                default:
                begin
                    tbl_wr_en = 1'b0;
                end
            endcase
        end
    end

    // The read for entry zero goes out with the accepted transaction, so the
    // scan sees one entry per cycle.
    assign tbl_rd_en   = (state_reg == S_SCAN) || (state_reg == S_IDLE && req_valid);
    assign tbl_rd_addr = (state_reg == S_SCAN) ? chk_reg + wpsm_pkg::SLOT_AW'(1) : '0;
    assign tbl_wr_addr = chk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            req_reg    <= '0;
            chk_reg    <= '0;
            code_reg   <= wpsm_pkg::RC_OK;
            slot_reg   <= '0;
            rel_reg    <= '0;
            grow_reg   <= '0;
            shrink_reg <= '0;
            active_reg <= '0;
            idle_reg   <= '0;
            work_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg    <= req;
                        chk_reg    <= '0;
                        code_reg   <= wpsm_pkg::RC_OK;
                        slot_reg   <= '0;
                        rel_reg    <= '0;
                        grow_reg   <= '0;
                        shrink_reg <= '0;
                        case (req.cmd)
                            wpsm_pkg::CMD_ADD:
                            begin
                                if (active_cmp >= CMP_W'(cfg.max_workers))
                                begin
                                    code_reg  <= wpsm_pkg::RC_FULL;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            wpsm_pkg::CMD_RELEASE:
                            begin
                                if (active_cmp <= CMP_W'(cfg.min_workers))
                                begin
                                    code_reg  <= wpsm_pkg::RC_MIN;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            wpsm_pkg::CMD_SET:
                            begin
                                state_reg <= S_SCAN;
                            end
                            default:
                            begin
                                if (idle_cmp <= CMP_W'(cfg.idle_delta))
                                begin
                                    grow_reg <= wpsm_pkg::GROW_W'(CMP_W'(cfg.idle_delta)
                                                                  - idle_cmp);
                                end
                                else if (idle_cmp > CMP_W'(delta_x3))
                                begin
                                    shrink_reg <= wpsm_pkg::COUNT_W'(idle_cmp
                                                                     - CMP_W'(delta_x3));
                                end
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        slot_reg   <= chk_reg;
                        active_reg <= active_next;
                        idle_reg   <= idle_next;
                        work_reg   <= work_next;
                        if (req_reg.cmd == wpsm_pkg::CMD_RELEASE)
                        begin
                            rel_reg <= tbl_rd_entry.id;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (chk_reg == LAST_SLOT)
                    begin
                        code_reg  <= miss_code;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        chk_reg <= chk_reg + wpsm_pkg::SLOT_AW'(1);
                    end
                end
                S_DONE:
                begin
                    if (rsp_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);

    always_comb
    begin
        rsp.result_code   = code_reg;
        rsp.slot_index    = wpsm_pkg::SLOT_IDX_W'(slot_reg);
        rsp.released_id   = rel_reg;
        rsp.grow_count    = grow_reg;
        rsp.shrink_count  = shrink_reg;
        rsp.active_count  = wpsm_pkg::COUNT_W'(active_reg);
        rsp.idle_count    = wpsm_pkg::COUNT_W'(idle_reg);
        rsp.working_count = wpsm_pkg::COUNT_W'(work_reg);
    end

endmodule

// File: sv/worker_pool_slot_manager.sv
// ----------------------------------------------------------------------------
// worker_pool_slot_manager
// Worker pool slot table with add, set-state, release and grow/shrink
// evaluation commands, one result transaction per command.
// ----------------------------------------------------------------------------
// One command is handled at a time. Evaluate and commands refused by the
// worker limits go from acceptance straight to the result state without a
// scan, and the next command is accepted once that result is passed on. Add,
// set-state and release scan the slot table through its single read port,
// one entry per cycle, and stop at the first matching slot or, when nothing
// matches, after the last of the SLOTS entries (64 slots). The result
// register lets the next command be accepted while a result waits on the
// master side. Configuration writes are always accepted and take effect on
// the next command; they are meant to be issued while no command is pending.
module worker_pool_slot_manager
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Command channel.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // worker_id [30:0], new_state [32:31], zero padding [39:33].
    input  logic [wpsm_pkg::IN_TDATA_W-1:0]      s_tdata,
    // command [1:0].
    input  logic [wpsm_pkg::IN_TUSER_W-1:0]      s_tuser,
    // Result channel.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // result_code [2:0], slot_index [8:3], released_id [39:9],
    // grow_count [44:40], shrink_count [51:45], active_count [58:52],
    // idle_count [65:59], working_count [72:66], zero padding [79:73].
    output logic [wpsm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wpsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wpsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    wpsm_pkg::cfg_t                      cfg_reg;
    wpsm_pkg::req_t                      req;
    wpsm_pkg::rsp_t                      rsp;
    logic                                req_ready;
    logic                                rsp_valid;
    logic                                rsp_ready;
    logic                                m_tvalid_reg;
    logic [wpsm_pkg::OUT_TDATA_W-1:0]    m_tdata_reg;

    logic                                tbl_rd_en;
    logic [wpsm_pkg::SLOT_AW-1:0]        tbl_rd_addr;
    logic                                tbl_wr_en;
    logic [wpsm_pkg::SLOT_AW-1:0]        tbl_wr_addr;
    wpsm_pkg::slot_entry_t               tbl_wr_entry;
    wpsm_pkg::slot_entry_t               tbl_rd_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_workers <= wpsm_pkg::LIMIT_W'(5);
            cfg_reg.max_workers <= wpsm_pkg::LIMIT_W'(64);
            cfg_reg.idle_delta  <= wpsm_pkg::DELTA_W'(5);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wpsm_pkg::CFG_MIN_WORKERS: cfg_reg.min_workers <= cfg_data;
                wpsm_pkg::CFG_MAX_WORKERS: cfg_reg.max_workers <= cfg_data;
                wpsm_pkg::CFG_IDLE_DELTA:
                begin
                    cfg_reg.idle_delta <= cfg_data[wpsm_pkg::DELTA_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign req.cmd       = wpsm_pkg::cmd_t'(s_tuser);
    assign req.worker_id = s_tdata[wpsm_pkg::ID_W-1:0];
    assign req.new_state = s_tdata[wpsm_pkg::ID_W +: wpsm_pkg::STATE_W];
    assign s_tready      = req_ready;

    wpsm_table u_table
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_wr_addr),
        .wr_entry (tbl_wr_entry),
        .rd_entry (tbl_rd_entry)
    );

    wpsm_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (s_tvalid),
        .req          (req),
        .req_ready    (req_ready),
        .cfg          (cfg_reg),
        .rsp_valid    (rsp_valid),
        .rsp          (rsp),
        .rsp_ready    (rsp_ready),
        .tbl_rd_en    (tbl_rd_en),
        .tbl_rd_addr  (tbl_rd_addr),
        .tbl_wr_en    (tbl_wr_en),
        .tbl_wr_addr  (tbl_wr_addr),
        .tbl_wr_entry (tbl_wr_entry),
        .tbl_rd_entry (tbl_rd_entry)
    );

    // Output register: takes a new result whenever it is empty or being drained.
    assign rsp_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else if (rsp_ready)
        begin
            m_tvalid_reg <= rsp_valid;
            if (rsp_valid)
            begin
                m_tdata_reg <= wpsm_pkg::OUT_TDATA_W'(rsp);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: sv/wpsm_checker.sv
// ----------------------------------------------------------------------------
// wpsm_port_checks
// Port-level checks of the worker pool slot manager, bound to the top level.
// ----------------------------------------------------------------------------
module wpsm_port_checks
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [wpsm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    wpsm_pkg::rsp_t                  rsp;
    logic [wpsm_pkg::COUNT_W-1:0]    busy_sum;

    assign rsp      = m_tdata[$bits(wpsm_pkg::rsp_t)-1:0];
    assign busy_sum = rsp.idle_count + rsp.working_count;

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every active slot is either idle or working.
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> busy_sum == rsp.active_count)
        else $error("idle plus working differs from active");

    // The hysteresis rule never asks to grow and shrink at once.
    a_grow_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> rsp.grow_count == '0 || rsp.shrink_count == '0)
        else $error("grow and shrink both nonzero");

    // A refused command reports no slot and no released worker.
    a_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && rsp.result_code != wpsm_pkg::RC_OK
            |-> rsp.slot_index == '0 && rsp.released_id == '0)
        else $error("refused command carries a slot or an id");

endmodule

bind worker_pool_slot_manager wpsm_port_checks u_wpsm_port_checks (.*);
